>>> hdl/tlc_pkg.sv
// Shared types and codes for the threshold leader clustering block.
// No dependencies; imported by tlc_cell and threshold_leader_clustering_top.
package tlc_pkg;

    localparam int VALUE_W  = 16;
    localparam int COUNT_W  = 32;
    localparam int CCOUNT_W = 5;

    typedef enum logic [2:0] {
        ST_NEW     = 3'd0,
        ST_MATCH   = 3'd1,
        ST_NOCONV  = 3'd2,
        ST_FULL    = 3'd3,
        ST_IGNORED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD,
        S_DUMP
    } state_t;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_ENTRY  = 1'b1;

    // register select bit of paddr
    localparam logic ADDR_THRESHOLD = 1'b0;

    typedef struct packed {
        logic cmp_en;
        logic inc_en;
        logic load_en;
        logic shift_en;
    } cell_ctrl_t;

endpackage

>>> hdl/tlc_cell.sv
// One table cell: holds a representative and its member count, compares the
// sample against it and shifts toward cell 0 during the dump. Uses tlc_pkg.
module tlc_cell
    import tlc_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int UW    = 5
)
(
    input  logic                      clk,
    input  cell_ctrl_t                ctrl,
    input  logic [UW-1:0]             used,
    input  logic signed [VALUE_W-1:0] sample,
    input  logic [VALUE_W-1:0]        threshold,
    input  logic signed [VALUE_W-1:0] next_value,
    input  logic [COUNT_W-1:0]        next_count,
    output logic signed [VALUE_W-1:0] value,
    output logic [COUNT_W-1:0]        count,
    output logic                      match
);

    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic                      match_reg, match_next;
    logic signed [VALUE_W:0]   diff;
    logic [VALUE_W:0]          mag;
    logic                      occupied;
    logic                      slot_here;

    assign occupied  = used > UW'(INDEX);
    assign slot_here = used == UW'(INDEX);

    assign diff = {value_reg[VALUE_W-1], value_reg} - {sample[VALUE_W-1], sample};
    assign mag  = diff[VALUE_W] ? -diff : diff;

    always_comb
    begin
        value_next = value_reg;
        count_next = count_reg;
        match_next = match_reg;
        if (ctrl.cmp_en)
        begin
            match_next = occupied && (mag < {1'b0, threshold});
        end
        if (ctrl.shift_en)
        begin
            value_next = next_value;
            count_next = next_count;
        end
        else if (ctrl.load_en && slot_here)
        begin
            value_next = sample;
            count_next = COUNT_W'(1);
        end
        else if (ctrl.inc_en && match_reg && (count_reg != '1))
        begin
            count_next = count_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        count_reg <= count_next;
        match_reg <= match_next;
    end

    assign value = value_reg;
    assign count = count_reg;
    assign match = match_reg;

endmodule

>>> hdl/threshold_leader_clustering_top.sv
// Top level of the threshold leader clustering block: APB threshold register,
// control sequencer, output register and the chain of tlc_cell instances.
// Depends on tlc_pkg and tlc_cell.
//
// Usage:
//   Samples arrive on s_axis (opinion in tdata, end of run on tlast). Results
//   leave on m_axis: tuser is the kind (sample status or table entry), tlast
//   marks the final result of a run. match_threshold is written over APB at
//   byte address 0 while the block is idle.
//   Each sample passes through accept, parallel compare in every cell
//   (registered match flags), then decode of the match vector, count update,
//   append and status word; the next sample is taken only back in idle.
//   The status word is registered when the output register is free. On the
//   last sample of a converged run the table is shifted out of cell 0, one
//   entry word per cycle while the receiver does not stall.
//   When the receiver stalls, the output register holds its word and the
//   sequencer waits; a new sample is still taken while a word is pending.
//   Reset empties the table, clears the not-converged flag and the
//   threshold; no clearing pass is needed.
module threshold_leader_clustering_top
    import tlc_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // sample stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] opinion
    input  logic        s_axis_tlast,   // last_sample
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] status, [7:3] cluster_count, [23:8] entry_value, [55:24] entry_count
    output logic [55:0] m_axis_tdata,
    output logic [0:0]  m_axis_tuser,   // [0] kind
    output logic        m_axis_tlast    // last
);

    localparam int UW = $clog2(TABLE_DEPTH + 1);

    state_t state_reg, state_next;

    logic [VALUE_W-1:0]        threshold_reg;
    logic signed [VALUE_W-1:0] sample_reg;
    logic                      last_reg;
    logic [UW-1:0]             used_reg, used_next, used_after;
    logic                      nc_reg, nc_next, nc_after;
    logic [UW-1:0]             dump_left_reg, dump_left_next;
    logic [UW-1:0]             dump_total_reg, dump_total_next;

    logic                      out_valid_reg, out_valid_next;
    logic                      out_kind_reg, out_kind_next;
    status_t                   out_status_reg, out_status_next;
    logic [CCOUNT_W-1:0]       out_ccount_reg, out_ccount_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    logic [COUNT_W-1:0]        out_count_reg, out_count_next;
    logic                      out_last_reg, out_last_next;

    logic                      out_free;
    logic                      upd_fire;
    logic                      dump_fire;
    logic                      do_dump;
    logic                      none_match;
    logic                      many_match;
    status_t                   status_now;
    cell_ctrl_t                ctrl;
    logic                      cfg_write;

    logic signed [VALUE_W-1:0] cell_value [TABLE_DEPTH];
    logic [COUNT_W-1:0]        cell_count [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]    match_vec;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == ADDR_THRESHOLD) ? {16'b0, threshold_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
        end
        else if (cfg_write && (paddr[2] == ADDR_THRESHOLD))
        begin
            threshold_reg <= pwdata[VALUE_W-1:0];
        end
    end

    // ---------------- cell chain ----------------
    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            logic signed [VALUE_W-1:0] nb_value;
            logic [COUNT_W-1:0]        nb_count;
            if (gi == TABLE_DEPTH - 1)
            begin : g_end
                assign nb_value = cell_value[gi];
                assign nb_count = cell_count[gi];
            end
            else
            begin : g_mid
                assign nb_value = cell_value[gi+1];
                assign nb_count = cell_count[gi+1];
            end
            tlc_cell #(
                .INDEX (gi),
                .UW    (UW)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .used       (used_reg),
                .sample     (sample_reg),
                .threshold  (threshold_reg),
                .next_value (nb_value),
                .next_count (nb_count),
                .value      (cell_value[gi]),
                .count      (cell_count[gi]),
                .match      (match_vec[gi])
            );
        end
    endgenerate

    // zero, one or several matches
    assign none_match = ~|match_vec;
    assign many_match = |(match_vec & (match_vec - TABLE_DEPTH'(1)));

    // ---------------- sequencer ----------------
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign upd_fire  = (state_reg == S_UPD) && out_free;
    assign dump_fire = (state_reg == S_DUMP) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (out_free)
                begin
                    state_next = do_dump ? S_DUMP : S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (out_free && (dump_left_reg == UW'(1)))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == S_IDLE);
        ctrl.cmp_en   = (state_reg == S_CMP);
        ctrl.inc_en   = upd_fire && !nc_reg;
        ctrl.load_en  = upd_fire && !nc_reg && none_match && (used_reg < UW'(TABLE_DEPTH));
        ctrl.shift_en = dump_fire;
    end

    always_comb
    begin
        if (nc_reg)
        begin
            status_now = ST_IGNORED;
        end
        else if (none_match)
        begin
            status_now = (used_reg < UW'(TABLE_DEPTH)) ? ST_NEW : ST_FULL;
        end
        else if (many_match)
        begin
            status_now = ST_NOCONV;
        end
        else
        begin
            status_now = ST_MATCH;
        end
        used_after = ctrl.load_en ? used_reg + UW'(1) : used_reg;
        nc_after   = nc_reg || (status_now == ST_NOCONV);
        do_dump    = last_reg && !nc_after && (used_after != '0);
    end

    always_comb
    begin
        used_next       = used_reg;
        nc_next         = nc_reg;
        dump_left_next  = dump_left_reg;
        dump_total_next = dump_total_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_kind_next   = out_kind_reg;
        out_status_next = out_status_reg;
        out_ccount_next = out_ccount_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        if (upd_fire)
        begin
            // run ends: table is cleared, the dump works from the cells alone
            used_next       = last_reg ? '0 : used_after;
            nc_next         = last_reg ? 1'b0 : nc_after;
            dump_left_next  = used_after;
            dump_total_next = used_after;
            out_valid_next  = 1'b1;
            out_kind_next   = KIND_STATUS;
            out_status_next = status_now;
            out_ccount_next = CCOUNT_W'(used_after);
            out_value_next  = '0;
            out_count_next  = '0;
            out_last_next   = last_reg && !do_dump;
        end
        else if (dump_fire)
        begin
            dump_left_next  = dump_left_reg - UW'(1);
            out_valid_next  = 1'b1;
            out_kind_next   = KIND_ENTRY;
            out_status_next = ST_NEW;
            out_ccount_next = CCOUNT_W'(dump_total_reg);
            out_value_next  = cell_value[0];
            out_count_next  = cell_count[0];
            out_last_next   = (dump_left_reg == UW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            nc_reg        <= 1'b0;
            dump_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            nc_reg        <= nc_next;
            dump_left_reg <= dump_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            sample_reg <= s_axis_tdata;
            last_reg   <= s_axis_tlast;
        end
        dump_total_reg <= dump_total_next;
        out_kind_reg   <= out_kind_next;
        out_status_reg <= out_status_next;
        out_ccount_reg <= out_ccount_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_count_reg, out_value_reg, out_ccount_reg, out_status_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(TABLE_DEPTH))
        else $error("table fill beyond depth");

    a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |-> (dump_left_reg != '0))
        else $error("dump with no entries left");

    a_dump_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |-> ((used_reg == '0) && !nc_reg))
        else $error("run state not cleared during dump");

    a_nc_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(nc_reg) |-> ($past(state_reg) == S_UPD))
        else $error("not-converged set outside update");
`endif

endmodule

>>> tb/threshold_leader_clustering_top_tb.sv
// Self-checking testbench for threshold_leader_clustering_top: directed and random
// sample runs, with the expected status and table words predicted in the bench.
// Depends on tlc_pkg and the RTL of threshold_leader_clustering_top.
`timescale 1ns / 1ps

module threshold_leader_clustering_top_tb;
    import tlc_pkg::*;

    localparam int          TABLE_DEPTH    = 16;
    localparam logic [2:0]  THRESHOLD_ADDR = 3'd0;
    localparam int          DRAIN_CYCLES   = 40;
    localparam int          LONG_HOLD      = 300;
    localparam int          HOLD_AFTER     = 100;

    typedef struct packed {
        logic signed [15:0] opinion;
        logic               last_sample;
    } sample_t;

    typedef struct packed {
        logic               kind;
        status_t            status;
        logic [4:0]         clusters;
        logic signed [15:0] rep_value;
        logic [31:0]        rep_count;
        logic               last;
    } result_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_data = '0;
    logic        s_last = 1'b0;
    logic        m_axis_tvalid;
    logic        m_ready = 1'b0;
    logic        hold_rx = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    threshold_leader_clustering_top #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready && !hold_rx),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #3_000_000;
        $display("threshold_leader_clustering_top regression: fail");
        $finish;
    end

    // bench copy of the clustering table
    logic [15:0]        thr_m;
    logic signed [15:0] rep_m [TABLE_DEPTH];
    logic [31:0]        cnt_m [TABLE_DEPTH];
    int                 used_m;
    logic               noconv_m;

    sample_t      pending_samples [$];
    result_word_t expected_words [$];
    int           errors;

    task automatic cluster_sample(input logic signed [15:0] op, input logic lst);
        int           hits;
        int           d;
        logic         dump;
        status_t      st;
        result_word_t w;
        hits = 0;
        if (noconv_m)
            st = ST_IGNORED;
        else
        begin
            for (int i = 0; i < used_m; i++)
            begin
                d = int'(rep_m[i]) - int'(op);
                if (d < 0)
                    d = -d;
                if (d < int'(thr_m))
                begin
                    hits++;
                    if (cnt_m[i] != '1)
                        cnt_m[i] = cnt_m[i] + 1;
                end
            end
            if (hits == 0)
            begin
                if (used_m < TABLE_DEPTH)
                begin
                    rep_m[used_m] = op;
                    cnt_m[used_m] = 1;
                    used_m++;
                    st = ST_NEW;
                end
                else
                    st = ST_FULL;
            end
            else if (hits == 1)
                st = ST_MATCH;
            else
            begin
                st = ST_NOCONV;
                noconv_m = 1'b1;
            end
        end
        dump = lst && !noconv_m && used_m > 0;
        w.kind      = KIND_STATUS;
        w.status    = st;
        w.clusters  = 5'(used_m);
        w.rep_value = '0;
        w.rep_count = '0;
        w.last      = lst && !dump;
        expected_words.insert(expected_words.size(), w);
        if (dump)
        begin
            for (int i = 0; i < used_m; i++)
            begin
                w.kind      = KIND_ENTRY;
                w.status    = ST_NEW;
                w.clusters  = 5'(used_m);
                w.rep_value = rep_m[i];
                w.rep_count = cnt_m[i];
                w.last      = (i + 1 == used_m);
                expected_words.insert(expected_words.size(), w);
            end
        end
        if (lst)
        begin
            used_m   = 0;
            noconv_m = 1'b0;
        end
    endtask

    // sample driver
    int tx_wait;
    bit tx_burst;

    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        sample_t s;
        if (!rst_n)
        begin
            s_valid  <= 1'b0;
            s_data   <= '0;
            s_last   <= 1'b0;
            tx_wait  = 0;
            tx_burst = 1'b0;
        end
        else
        begin
            if (s_valid && s_axis_tready)
                cluster_sample(s_data, s_last);
            if (!s_valid || s_axis_tready)
            begin
                if (tx_wait != 0)
                begin
                    s_valid <= 1'b0;
                    tx_wait--;
                end
                else if (pending_samples.size() != 0)
                begin
                    s = pending_samples.pop_front();
                    s_data  <= s.opinion;
                    s_last  <= s.last_sample;
                    s_valid <= 1'b1;
                    if ($urandom_range(0, 15) == 0)
                        tx_burst = !tx_burst;
                    tx_wait = tx_burst ? 0 : $urandom_range(0, 10);
                end
                else
                    s_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    int rx_wait;
    int words_seen;
    bit rx_burst;

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        result_word_t exp_w;
        int           w;
        if (!rst_n)
        begin
            m_ready    <= 1'b0;
            rx_wait    = 0;
            words_seen = 0;
            rx_burst   = 1'b0;
        end
        else if (m_axis_tvalid && m_ready && !hold_rx)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word: tuser %h tdata %h", m_axis_tuser,
                       m_axis_tdata);
                errors++;
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (m_axis_tuser[0] !== exp_w.kind)
                begin
                    $error("kind: expected %0d, actual %0d", exp_w.kind, m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tdata[2:0] !== exp_w.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_w.status,
                           m_axis_tdata[2:0]);
                    errors++;
                end
                if (m_axis_tdata[7:3] !== exp_w.clusters)
                begin
                    $error("cluster_count: expected %0d, actual %0d", exp_w.clusters,
                           m_axis_tdata[7:3]);
                    errors++;
                end
                if (m_axis_tdata[23:8] !== exp_w.rep_value)
                begin
                    $error("entry_value: expected %0d, actual %0d", exp_w.rep_value,
                           $signed(m_axis_tdata[23:8]));
                    errors++;
                end
                if (m_axis_tdata[55:24] !== exp_w.rep_count)
                begin
                    $error("entry_count: expected %0d, actual %0d", exp_w.rep_count,
                           m_axis_tdata[55:24]);
                    errors++;
                end
                if (m_axis_tlast !== exp_w.last)
                begin
                    $error("last: expected %0d, actual %0d", exp_w.last, m_axis_tlast);
                    errors++;
                end
            end
            words_seen++;
            // two long hold-offs let the block back up into its input
            if (words_seen == 30 || words_seen == 150)
                w = LONG_HOLD;
            else
            begin
                if ($urandom_range(0, 15) == 0)
                    rx_burst = !rx_burst;
                w = rx_burst ? 0 : $urandom_range(0, 10);
            end
            if (w == 0)
                m_ready <= 1'b1;
            else
            begin
                m_ready <= 1'b0;
                rx_wait = w - 1;
            end
        end
        else if (!m_ready)
        begin
            if (rx_wait == 0)
                m_ready <= 1'b1;
            else
                rx_wait--;
        end
    end

    // one long receiver stall, started while the sender is offering a word
    int hold_left;
    bit hold_done;

    always @(posedge clk or negedge rst_n)
    begin : long_stall
        if (!rst_n)
        begin
            hold_rx   <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else if (hold_rx)
        begin
            if (hold_left == 0)
                hold_rx <= 1'b0;
            else
                hold_left--;
        end
        else if (!hold_done && words_seen >= HOLD_AFTER && s_valid)
        begin
            hold_rx   <= 1'b1;
            hold_left = LONG_HOLD - 1;
            hold_done = 1'b1;
        end
    end

    task automatic queue_sample(input logic [15:0] op, input logic lst);
        sample_t s;
        s.opinion     = op;
        s.last_sample = lst;
        pending_samples.insert(pending_samples.size(), s);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || s_valid || expected_words.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [15:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= THRESHOLD_ADDR;
        pwdata  <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        thr_m = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Runs of samples around a few centers spaced three thresholds apart, so that
    // jittered samples match exactly one entry; a tenth are random noise, or all with noise_only.
    task automatic queue_phase(input int thr, input int n_items, input int max_run,
                               input bit noise_only);
        int          left;
        int          run_len;
        int          n_cent;
        int          step;
        int          half;
        int          base;
        logic [15:0] centers [6];
        logic [15:0] op;
        left = n_items;
        while (left > 0)
        begin
            run_len = $urandom_range(1, max_run);
            if (run_len > left)
                run_len = left;
            n_cent = $urandom_range(1, 6);
            step   = 3 * thr + 3;
            half   = (thr > 0) ? (thr - 1) / 2 : 0;
            base   = $urandom;
            for (int k = 0; k < 6; k++)
                centers[k] = 16'(base + k * step);
            for (int j = 0; j < run_len; j++)
            begin
                if (noise_only || $urandom_range(0, 9) == 0)
                    op = 16'($urandom);
                else
                    op = 16'(int'(centers[$urandom_range(0, n_cent - 1)])
                             + int'($urandom_range(0, 2 * half)) - half);
                queue_sample(op, j == run_len - 1);
            end
            left -= run_len;
        end
    endtask

    initial
    begin
        errors   = 0;
        thr_m    = '0;
        used_m   = 0;
        noconv_m = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // zero threshold from reset: every sample is new until the table is full
        queue_sample(16'h8000, 1'b0);
        queue_sample(16'h7FFF, 1'b0);
        queue_sample(16'h0000, 1'b0);
        queue_sample(16'hFFFF, 1'b0);
        queue_sample(16'h0001, 1'b0);
        queue_sample(16'h0000, 1'b0);
        queue_sample(16'h4000, 1'b0);
        queue_sample(16'hC000, 1'b0);
        queue_sample(16'h1234, 1'b0);
        queue_sample(16'hEDCC, 1'b0);
        queue_sample(16'h7FFE, 1'b0);
        queue_sample(16'h8001, 1'b0);
        queue_sample(16'h0002, 1'b0);
        queue_sample(16'hFFFE, 1'b0);
        queue_sample(16'h0100, 1'b0);
        queue_sample(16'h5555, 1'b0);
        queue_sample(16'hAAAA, 1'b0);
        queue_sample(16'h0064, 1'b1);
        wait_idle();

        // new, single match, new, double match, then an ignored sample at end of run
        write_threshold(16'h1000);
        queue_sample(16'h0000, 1'b0);
        queue_sample(16'h0800, 1'b0);
        queue_sample(16'h1800, 1'b0);
        queue_sample(16'h0C00, 1'b0);
        queue_sample(16'h0064, 1'b1);
        wait_idle();

        // widest threshold: only the two extremes stay apart
        write_threshold(16'hFFFF);
        queue_sample(16'h8000, 1'b0);
        queue_sample(16'h7FFF, 1'b1);
        wait_idle();

        write_threshold(16'd1);
        queue_phase(1, 27, 20, 1'b0);
        wait_idle();

        for (int p = 0; p < 2; p++)
        begin
            write_threshold(16'($urandom_range(2, 3000)));
            queue_phase(int'(thr_m), 27, 16, 1'b0);
            wait_idle();
        end

        write_threshold(16'($urandom_range(0, 65535)));
        queue_phase(int'(thr_m), 27, 4, 1'b1);
        wait_idle();

        write_threshold(16'd0);
        queue_phase(0, 27, 20, 1'b0);
        wait_idle();

        if (errors == 0)
            $display("threshold_leader_clustering_top regression: pass");
        else
            $display("threshold_leader_clustering_top regression: fail");
        $finish;
    end

endmodule
